### hdl/fcbe_pkg.sv
// Shared types and constants of the front-coding block encoder.
// Depends on nothing; every other file of the block but fcbe_ram imports it.
package fcbe_pkg;

	localparam int MAX_WORD_BYTES_DEF = 32;
	localparam int LEN_W = 6;
	localparam int VALUE_W = 64;
	localparam int EPB_W = 16;
	localparam int COUNT_W = 32;

	localparam logic [EPB_W-1:0] EPB_RESET = 16'd16;

	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_LONG = 2'd1;
	localparam logic [1:0] STAT_BIG = 2'd2;

	localparam logic [1:0] KIND_RANGE = 2'd2;
	localparam logic [1:0] KIND_BAD = 2'd3;

	typedef enum logic [7:0] {
		S_IDLE     = 8'b0000_0001,
		S_SCAN_RD  = 8'b0000_0010,
		S_SCAN_CMP = 8'b0000_0100,
		S_DECIDE   = 8'b0000_1000,
		S_STAT     = 8'b0001_0000,
		S_VAR      = 8'b0010_0000,
		S_BYTE_RD  = 8'b0100_0000,
		S_BYTE_OUT = 8'b1000_0000
	} fcbe_state_t;

	typedef enum logic [3:0] {
		PH_HDR1 = 4'b0001,
		PH_HDR2 = 4'b0010,
		PH_VAL  = 4'b0100,
		PH_RNG  = 4'b1000
	} fcbe_phase_t;

endpackage

### hdl/fcbe_in_if.sv
// Input channel of the encoder: one word byte plus frequency tag.
// Depends on fcbe_pkg.
interface fcbe_in_if import fcbe_pkg::*; ();
	logic valid;
	logic ready;
	logic [7:0] word_byte;
	logic byte_present;
	logic word_end;
	logic [1:0] freq_kind;
	logic [VALUE_W-1:0] freq_value;
	logic [VALUE_W-1:0] freq_range_end;

	modport source(output valid, word_byte, byte_present, word_end, freq_kind, freq_value,
		freq_range_end, input ready);
	modport sink(input valid, word_byte, byte_present, word_end, freq_kind, freq_value,
		freq_range_end, output ready);
endinterface

### hdl/fcbe_out_if.sv
// Output channel of the encoder: one encoded byte or status word.
// Depends on fcbe_pkg.
interface fcbe_out_if import fcbe_pkg::*; ();
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic byte_valid;
	logic block_start;
	logic record_last;
	logic [1:0] status;
	logic [COUNT_W-1:0] entries_emitted;
	logic [LEN_W-1:0] longest_word;

	modport source(output valid, out_byte, byte_valid, block_start, record_last, status,
		entries_emitted, longest_word, input ready);
	modport sink(input valid, out_byte, byte_valid, block_start, record_last, status,
		entries_emitted, longest_word, output ready);
endinterface

### hdl/fcbe_cfg_if.sv
// Configuration write channel: entries_per_block.
// Depends on fcbe_pkg.
interface fcbe_cfg_if import fcbe_pkg::*; ();
	logic valid;
	logic ready;
	logic [EPB_W-1:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

### hdl/fcbe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module fcbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic clk,
	input  logic we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule

### hdl/front_coding_block_encoder_unit.sv
// Front-coding block encoder.
// word_in takes one byte of a sorted word per word; the word that carries
// word_end also carries the frequency tag. cfg writes entries_per_block and
// is always ready; write it only while the block is idle.
// rec_out delivers the encoded record one byte per word, record_last on its last;
// dropped words give one status word, duplicates give nothing.
// At word_end the block compares the word with the previous one byte by byte
// (a RAM read state, then a compare state, per shared byte), then emits one
// header or value byte per cycle while rec_out does not stall, and each suffix
// byte through a RAM read state and then an output state. word_in is not ready
// from word_end until the record's last word is loaded.
// Both word buffers live in RAMs with registered read data; the previous word is
// rewritten while the suffix streams out.
// Reset clears all counters and lengths; RAM contents need no clearing.
// A stall on rec_out holds the output register and freezes the sequencer in its output states.
// Depends on fcbe_pkg, the three channel interfaces and fcbe_ram.
module front_coding_block_encoder_unit import fcbe_pkg::*; #(
	parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	fcbe_in_if.sink word_in,
	fcbe_out_if.source rec_out,
	fcbe_cfg_if.sink cfg
);
	localparam int AW = MAX_WORD_BYTES > 1 ? $clog2(MAX_WORD_BYTES) : 1;
	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_WORD_BYTES);

	fcbe_state_t state_q;
	fcbe_phase_t phase_q;
	logic [EPB_W-1:0] epb_q, pos_q;
	logic [LEN_W-1:0] cur_len_q, prev_len_q, max_len_q, idx_q, ptr_q;
	logic ovf_q, has_prev_q, opens_q, first_q;
	logic [COUNT_W-1:0] count_q;
	logic [1:0] kind_q, stat_q;
	logic [VALUE_W-1:0] value_q, range_q, v_q;

	logic out_valid_q, out_bvalid_q, out_start_q, out_last_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_stat_q;
	logic [COUNT_W-1:0] out_count_q;
	logic [LEN_W-1:0] out_long_q;

	logic in_acc, out_free, out_load, fits, ovf_now, rest_nz, dup, bad, opens_now;
	logic [LEN_W-1:0] lim, ptr_nx;
	logic [EPB_W:0] pos_inc;
	logic cur_we, cur_re, prev_we, prev_re;
	logic [7:0] cur_rdata, prev_rdata;

	assign word_in.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign in_acc = word_in.valid & word_in.ready;
	assign out_free = !out_valid_q || rec_out.ready;
	assign out_load = out_free &&
		(state_q == S_STAT || state_q == S_VAR || state_q == S_BYTE_OUT);
	assign fits = cur_len_q < MAX_LEN;
	assign ovf_now = ovf_q || (word_in.byte_present && !fits);
	assign lim = (cur_len_q < prev_len_q) ? cur_len_q : prev_len_q;
	assign rest_nz = |v_q[VALUE_W-1:7];
	assign dup = has_prev_q && (cur_len_q == prev_len_q) && (idx_q == cur_len_q);
	assign bad = (kind_q == KIND_BAD) || (|value_q[VALUE_W-1:VALUE_W-2]);
	assign opens_now = (pos_q == '0);
	assign ptr_nx = ptr_q + LEN_W'(1);
	assign pos_inc = {1'b0, pos_q} + (EPB_W+1)'(1);

	assign cur_we = in_acc && word_in.byte_present && fits;
	assign cur_re = (state_q == S_SCAN_RD && idx_q < lim) || state_q == S_BYTE_RD;
	assign prev_re = (state_q == S_SCAN_RD && idx_q < lim);
	assign prev_we = (state_q == S_BYTE_OUT) && out_free;

	fcbe_ram #(.WIDTH(8), .DEPTH(MAX_WORD_BYTES)) u_cur_ram (
		.clk(clk), .we(cur_we), .waddr(cur_len_q[AW-1:0]), .wdata(word_in.word_byte),
		.re(cur_re),
		.raddr(state_q == S_SCAN_RD ? idx_q[AW-1:0] : ptr_q[AW-1:0]),
		.rdata(cur_rdata)
	);

	fcbe_ram #(.WIDTH(8), .DEPTH(MAX_WORD_BYTES)) u_prev_ram (
		.clk(clk), .we(prev_we), .waddr(ptr_q[AW-1:0]), .wdata(cur_rdata),
		.re(prev_re), .raddr(idx_q[AW-1:0]), .rdata(prev_rdata)
	);

	assign rec_out.valid = out_valid_q;
	assign rec_out.out_byte = out_byte_q;
	assign rec_out.byte_valid = out_bvalid_q;
	assign rec_out.block_start = out_start_q;
	assign rec_out.record_last = out_last_q;
	assign rec_out.status = out_stat_q;
	assign rec_out.entries_emitted = out_count_q;
	assign rec_out.longest_word = out_long_q;

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc && word_in.word_end) begin
			kind_q <= word_in.freq_kind;
			value_q <= word_in.freq_value;
			range_q <= word_in.freq_range_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= PH_HDR1;
			epb_q <= EPB_RESET;
			pos_q <= '0;
			cur_len_q <= '0;
			prev_len_q <= '0;
			max_len_q <= '0;
			idx_q <= '0;
			ptr_q <= '0;
			ovf_q <= 1'b0;
			has_prev_q <= 1'b0;
			opens_q <= 1'b0;
			first_q <= 1'b0;
			count_q <= '0;
			stat_q <= STAT_OK;
			v_q <= '0;
			out_valid_q <= 1'b0;
			out_bvalid_q <= 1'b0;
			out_start_q <= 1'b0;
			out_last_q <= 1'b0;
			out_byte_q <= '0;
			out_stat_q <= STAT_OK;
			out_count_q <= '0;
			out_long_q <= '0;
		end else begin
			if (cfg.valid)
				epb_q <= cfg.data;
			if (out_load)
				out_valid_q <= 1'b1;
			else if (rec_out.ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (word_in.byte_present && fits)
							cur_len_q <= cur_len_q + LEN_W'(1);
						if (word_in.byte_present && !fits)
							ovf_q <= 1'b1;
						if (word_in.word_end) begin
							idx_q <= '0;
							if (ovf_now) begin
								stat_q <= STAT_LONG;
								state_q <= S_STAT;
							end else begin
								state_q <= S_SCAN_RD;
							end
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= (idx_q < lim) ? S_SCAN_CMP : S_DECIDE;
				end
				S_SCAN_CMP: begin
					if (cur_rdata == prev_rdata) begin
						idx_q <= idx_q + LEN_W'(1);
						state_q <= S_SCAN_RD;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (dup) begin
						cur_len_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end else if (bad) begin
						stat_q <= STAT_BIG;
						state_q <= S_STAT;
					end else begin
						opens_q <= opens_now;
						first_q <= opens_now;
						ptr_q <= opens_now ? '0 : idx_q;
						v_q <= opens_now ? VALUE_W'(cur_len_q) : VALUE_W'(idx_q);
						phase_q <= PH_HDR1;
						count_q <= count_q + COUNT_W'(1);
						if (cur_len_q > max_len_q)
							max_len_q <= cur_len_q;
						state_q <= S_VAR;
					end
				end
				S_STAT: begin
					if (out_free) begin
						out_byte_q <= '0;
						out_bvalid_q <= 1'b0;
						out_start_q <= 1'b0;
						out_last_q <= 1'b1;
						out_stat_q <= stat_q;
						out_count_q <= count_q;
						out_long_q <= max_len_q;
						cur_len_q <= '0;
						ovf_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_VAR: begin
					if (out_free) begin
						out_byte_q <= {rest_nz, v_q[6:0]};
						out_bvalid_q <= 1'b1;
						out_start_q <= first_q;
						out_last_q <= !rest_nz && (phase_q == PH_RNG ||
							(phase_q == PH_VAL && kind_q != KIND_RANGE));
						out_stat_q <= STAT_OK;
						out_count_q <= count_q;
						out_long_q <= max_len_q;
						first_q <= 1'b0;
						if (rest_nz) begin
							v_q <= v_q >> 7;
						end else begin
							case (phase_q)
								PH_HDR1, PH_HDR2: begin
									if (phase_q == PH_HDR1 && !opens_q) begin
										phase_q <= PH_HDR2;
										v_q <= VALUE_W'(cur_len_q - ptr_q);
									end else if (ptr_q < cur_len_q) begin
										state_q <= S_BYTE_RD;
									end else begin
										phase_q <= PH_VAL;
										v_q <= {value_q[VALUE_W-3:0], kind_q};
									end
								end
								PH_VAL: begin
									if (kind_q == KIND_RANGE) begin
										phase_q <= PH_RNG;
										v_q <= range_q;
									end else begin
										prev_len_q <= cur_len_q;
										has_prev_q <= 1'b1;
										pos_q <= (pos_inc >= {1'b0, epb_q}) ? '0 : pos_inc[EPB_W-1:0];
										cur_len_q <= '0;
										ovf_q <= 1'b0;
										state_q <= S_IDLE;
									end
								end
								PH_RNG: begin
									prev_len_q <= cur_len_q;
									has_prev_q <= 1'b1;
									pos_q <= (pos_inc >= {1'b0, epb_q}) ? '0 : pos_inc[EPB_W-1:0];
									cur_len_q <= '0;
									ovf_q <= 1'b0;
									state_q <= S_IDLE;
								end
								default: state_q <= S_IDLE;
							endcase
						end
					end
				end
				S_BYTE_RD: begin
					state_q <= S_BYTE_OUT;
				end
				S_BYTE_OUT: begin
					// copy the byte into the previous-word RAM as it leaves
					if (out_free) begin
						out_byte_q <= cur_rdata;
						out_bvalid_q <= 1'b1;
						out_start_q <= first_q;
						out_last_q <= 1'b0;
						out_stat_q <= STAT_OK;
						out_count_q <= count_q;
						out_long_q <= max_len_q;
						first_q <= 1'b0;
						ptr_q <= ptr_nx;
						if (ptr_nx < cur_len_q) begin
							state_q <= S_BYTE_RD;
						end else begin
							phase_q <= PH_VAL;
							v_q <= {value_q[VALUE_W-3:0], kind_q};
							state_q <= S_VAR;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

### tb/testbench.sv
// Self-checking testbench of the front-coding block encoder.
// Drives word bytes and block-size settings, predicts every output word in the bench,
// and compares each one as it leaves. Depends on fcbe_pkg, the channel interfaces and the RTL.
`timescale 1ns / 1ps
module testbench import fcbe_pkg::*; ();

	typedef struct packed {
		logic [7:0] out_byte;
		logic byte_valid;
		logic block_start;
		logic record_last;
		logic [1:0] status;
		logic [COUNT_W-1:0] entries_emitted;
		logic [LEN_W-1:0] longest_word;
	} rec_word_t;

	localparam int WORD_MAX = 32;
	localparam longint unsigned CYCLE_LIMIT = 64'd2000000;
	localparam int HOLD_CYCLES = 300;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	fcbe_in_if word_in ();
	fcbe_out_if rec_out ();
	fcbe_cfg_if cfg ();

	front_coding_block_encoder_unit dut (
		.clk(clk), .arst_n(arst_n), .word_in(word_in), .rec_out(rec_out), .cfg(cfg)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state
	logic [EPB_W-1:0] blk_size;
	logic [7:0] cur_buf [WORD_MAX];
	logic [7:0] prev_buf [WORD_MAX];
	int unsigned cur_len, prev_len, blk_pos;
	logic [COUNT_W-1:0] emit_count;
	logic [LEN_W-1:0] max_len;
	bit too_long, have_prev;

	rec_word_t expected_words[$];
	int mismatches = 0;
	longint unsigned cycles = 0;
	bit idle_enable = 1'b1;
	int hold_request = 0;
	int hold_taken = 0;
	int hold_off = 0;

	task automatic push_word(input logic [7:0] b, input logic v, input logic [1:0] st);
		rec_word_t w;
		w = '0;
		w.out_byte = b;
		w.byte_valid = v;
		w.status = st;
		w.entries_emitted = emit_count;
		w.longest_word = max_len;
		expected_words.insert(expected_words.size(), w);
	endtask

	task automatic push_varint(input logic [63:0] v);
		logic [7:0] b;
		do begin
			b = {1'b0, v[6:0]};
			v = v >> 7;
			if (v != 0) b[7] = 1'b1;
			push_word(b, 1'b1, STAT_OK);
		end while (v != 0);
	endtask

	task automatic predict_step(input logic [7:0] b, input logic pres, input logic fin,
			input logic [1:0] kind, input logic [63:0] val, input logic [63:0] rend);
		int unsigned pre, lim, first;
		bit opens, same;
		if (pres) begin
			if (cur_len < WORD_MAX) begin
				cur_buf[cur_len] = b;
				cur_len++;
			end else too_long = 1'b1;
		end
		if (!fin) return;
		if (too_long) begin
			push_word(8'd0, 1'b0, STAT_LONG);
			expected_words[$].record_last = 1'b1;
			cur_len = 0; too_long = 1'b0;
			return;
		end
		same = have_prev && cur_len == prev_len;
		for (int i = 0; same && i < cur_len; i++)
			if (cur_buf[i] != prev_buf[i]) same = 1'b0;
		if (same) begin
			cur_len = 0;
			return;
		end
		if (kind == KIND_BAD || val > 64'h3FFF_FFFF_FFFF_FFFF) begin
			push_word(8'd0, 1'b0, STAT_BIG);
			expected_words[$].record_last = 1'b1;
			cur_len = 0;
			return;
		end
		opens = (blk_pos == 0);
		pre = 0;
		if (!opens) begin
			lim = cur_len < prev_len ? cur_len : prev_len;
			while (pre < lim && cur_buf[pre] == prev_buf[pre]) pre++;
		end
		emit_count++;
		if (cur_len > max_len) max_len = cur_len[LEN_W-1:0];
		first = expected_words.size();
		if (opens) push_varint(64'(cur_len));
		else begin
			push_varint(64'(pre));
			push_varint(64'(cur_len - pre));
		end
		for (int i = pre; i < cur_len; i++) push_word(cur_buf[i], 1'b1, STAT_OK);
		push_varint({val[61:0], kind});
		if (kind == KIND_RANGE) push_varint(rend);
		if (opens) expected_words[first].block_start = 1'b1;
		expected_words[$].record_last = 1'b1;
		for (int i = 0; i < cur_len; i++) prev_buf[i] = cur_buf[i];
		prev_len = cur_len;
		have_prev = 1'b1;
		blk_pos++;
		if (blk_pos >= blk_size) blk_pos = 0;
		cur_len = 0;
	endtask

	function automatic bit idle_now();
		return idle_enable && $urandom_range(99) < 6;
	endfunction

	// send one input word and predict its effect once accepted; valid stays
	// high after acceptance until the next word or an idle cycle replaces it
	task automatic send_item(input logic [7:0] b, input logic pres, input logic fin,
			input logic [1:0] kind, input logic [63:0] val, input logic [63:0] rend);
		while (idle_now()) begin
			word_in.valid <= 1'b0;
			@(negedge clk);
		end
		word_in.word_byte <= b;
		word_in.byte_present <= pres;
		word_in.word_end <= fin;
		word_in.freq_kind <= kind;
		word_in.freq_value <= val;
		word_in.freq_range_end <= rend;
		word_in.valid <= 1'b1;
		do @(posedge clk); while (!word_in.ready);
		predict_step(b, pres, fin, kind, val, rend);
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom(), $urandom()};
		case ($urandom_range(3))
			0: v = v >> $urandom_range(63);
			1: v = v & 64'h3FFF_FFFF_FFFF_FFFF;
			2: v = v >> 56;
			default: ;
		endcase
		return v;
	endfunction

	function automatic logic [1:0] rand_kind();
		return $urandom_range(99) < 3 ? KIND_BAD : 2'($urandom_range(2));
	endfunction

	task automatic send_word(input logic [7:0] w [], input logic [1:0] kind,
			input logic [63:0] val, input logic [63:0] rend);
		if (w.size() == 0) send_item(8'd0, 1'b0, 1'b1, kind, val, rend);
		for (int i = 0; i < w.size(); i++)
			send_item(w[i], 1'b1, i == w.size() - 1, kind, val, rend);
	endtask

	task automatic wait_drained();
		word_in.valid <= 1'b0;
		while (expected_words.size() != 0) @(negedge clk);
		repeat (100) @(negedge clk);
	endtask

	task automatic write_block_size(input logic [EPB_W-1:0] v);
		wait_drained();
		cfg.data <= v;
		cfg.valid <= 1'b1;
		do @(posedge clk); while (!cfg.ready);
		blk_size = v;
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic test_directed();
		logic [7:0] w [];
		write_block_size(16'd3);
		w = '{8'h61};
		send_word(w, 2'd0, 64'd0, 64'd0);
		send_word(w, 2'd1, 64'd5, 64'd0);                  // duplicate gives nothing
		w = '{8'h61, 8'h62};
		send_word(w, 2'd1, 64'd300, 64'd0);
		w = '{8'h61, 8'h62, 8'hFF, 8'h00};
		send_word(w, KIND_RANGE, 64'h3FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
		w = '{8'h62};
		send_word(w, KIND_BAD, 64'd1, 64'd0);              // bad kind
		send_word(w, 2'd0, 64'h4000_0000_0000_0000, 64'd0); // value too big
		w = new[0];
		send_word(w, 2'd0, 64'd7, 64'd0);                  // empty word
		w = new[WORD_MAX];
		foreach (w[i]) w[i] = 8'hA5 ^ i[7:0];
		send_word(w, 2'd0, 64'd1, 64'd0);                  // longest that fits
		w = new[WORD_MAX + 3];
		foreach (w[i]) w[i] = 8'h7E;
		send_word(w, 2'd0, 64'd1, 64'd0);                  // too long
		w = '{8'hFF};
		send_word(w, KIND_RANGE, 64'd0, 64'd0);
	endtask

	task automatic test_random(input int n_items);
		logic [7:0] w [];
		logic [7:0] base [];
		int sent, keep, len;
		sent = 0;
		base = new[4];
		foreach (base[i]) base[i] = 8'($urandom());
		while (sent < n_items) begin
			len = $urandom_range(99) < 3 ? $urandom_range(WORD_MAX + 4, WORD_MAX + 1)
				: $urandom_range(8);
			keep = $urandom_range(base.size());
			if (keep > len) keep = len;
			w = new[len];
			foreach (w[i]) w[i] = i < keep ? base[i] : 8'($urandom());
			if ($urandom_range(9) == 0) w = base;   // repeat the last word that fit
			send_word(w, rand_kind(), rand_value(), {$urandom(), $urandom()});
			sent += w.size() == 0 ? 1 : w.size();
			if (w.size() <= WORD_MAX) base = w;
		end
	endtask

	task automatic test_backpressure();
		logic [7:0] w [];
		hold_request++;
		for (int k = 0; k < 6; k++) begin
			w = new[6];
			foreach (w[i]) w[i] = 8'(k * 7 + i);
			send_word(w, KIND_RANGE, rand_value() >> 2, 64'hFFFF_FFFF_FFFF_FFFF);
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_request != hold_taken) begin
			hold_taken <= hold_request;
			hold_off <= HOLD_CYCLES - 1;
			rec_out.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			rec_out.ready <= 1'b0;
		end else rec_out.ready <= !idle_now();
	end

	always @(posedge clk) begin
		rec_word_t got, want;
		cycles <= cycles + 1;
		if (arst_n && rec_out.valid && rec_out.ready) begin
			got = {rec_out.out_byte, rec_out.byte_valid, rec_out.block_start,
				rec_out.record_last, rec_out.status, rec_out.entries_emitted,
				rec_out.longest_word};
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", got);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		word_in.valid = 1'b0;
		word_in.word_byte = '0;
		word_in.byte_present = 1'b0;
		word_in.word_end = 1'b0;
		word_in.freq_kind = '0;
		word_in.freq_value = '0;
		word_in.freq_range_end = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		blk_size = EPB_RESET;
		cur_len = 0; prev_len = 0; blk_pos = 0;
		emit_count = '0; max_len = '0;
		too_long = 1'b0; have_prev = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_random(20);                  // reset block size first
		test_directed();
		write_block_size(16'd1);
		test_random(80);
		write_block_size(16'd0);
		test_random(40);
		write_block_size(16'hFFFF);
		test_random(80);
		test_backpressure();
		write_block_size(16'd4);
		idle_enable = 1'b0;
		test_random(80);                  // stretch with no idling
		idle_enable = 1'b1;
		write_block_size(16'd2);
		test_random(120);
		wait_drained();
		if (mismatches == 0 && expected_words.size() == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end

endmodule

### filelist.f
hdl/fcbe_pkg.sv
hdl/fcbe_in_if.sv
hdl/fcbe_out_if.sv
hdl/fcbe_cfg_if.sv
hdl/fcbe_ram.sv
hdl/front_coding_block_encoder_unit.sv
tb/testbench.sv
